@@ hdl/text_console_char_writer_core_defines.svh @@
// Assertion macros for the text console character writer checks.
`ifndef TEXT_CONSOLE_CHAR_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/tcw_pkg.sv @@
// Shared constants, types and codes of the text console character writer.
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELLS       = COLUMNS * ROWS;
    // The last row is never written, so only the rows above it are stored.
    localparam int STORE_ROWS  = ROWS - 1;
    localparam int STORE_CELLS = STORE_ROWS * COLUMNS;

    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int ADDR_W     = $clog2(STORE_CELLS);
    localparam int POS_CALC_W = $clog2(CELLS + 1);

    localparam int CMD_W   = 1;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int INDEX_W = 11;
    localparam int POS_W   = 11;
    localparam int CELL_W  = CHAR_W + ATTR_W;

    localparam logic [CMD_W-1:0] CMD_PUT  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_READ = 1'b1;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h02;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_RD_WAIT,
        ST_PUT,
        ST_BS_WAIT,
        ST_SCROLL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] wdata;
    } t_mem_req;

    typedef struct packed {
        logic [ROW_W-1:0] base;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_addr_req;

endpackage

`default_nettype wire

@@ hdl/tcw_if.sv @@
// Valid/ready channel interfaces: command input, result output, attribute write.
`default_nettype none

interface tcw_in_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::CMD_W-1:0]     command;
    logic [tcw_pkg::CHAR_W-1:0]    char_code;
    logic [tcw_pkg::INDEX_W-1:0]   cell_index;

    modport source (output valid, output command, output char_code, output cell_index,
                    input ready);
    modport sink   (input valid, input command, input char_code, input cell_index,
                    output ready);
endinterface

interface tcw_out_if;
    logic                        valid;
    logic                        ready;
    logic [tcw_pkg::POS_W-1:0]   cursor_position;
    logic [tcw_pkg::CHAR_W-1:0]  read_char;
    logic [tcw_pkg::ATTR_W-1:0]  read_attribute;

    modport source (output valid, output cursor_position, output read_char,
                    output read_attribute, input ready);
    modport sink   (input valid, input cursor_position, input read_char,
                    input read_attribute, output ready);
endinterface

interface tcw_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [tcw_pkg::ATTR_W-1:0]  text_attribute;

    modport source (output valid, output text_attribute, input ready);
    modport sink   (input valid, input text_attribute, output ready);
endinterface

`default_nettype wire

@@ hdl/text_console_char_writer_core.sv @@
// Text console character writer: top level.
// Keeps an 80x25 character/attribute screen and a cursor. After reset the block sweeps
// the cell store clear, one cell per cycle, over all 1920 cells (COLUMNS * (ROWS-1));
// input ready stays low during the sweep, while attribute writes are taken at any time.
// One command is processed at a time. A put moves the cursor and, for a printable
// character, writes its cell (a backspace reads the cell back, then clears its character);
// when it scrolls, the single write port of the cell store blanks one row of COLUMNS cells
// (80). A read walks the divide loop, which subtracts one row width per cycle from the
// cell index, then reads the cell (the last row reads as cleared without a read); an
// index past the screen skips both. Results sit in an output register; a new command
// is accepted while the previous result waits, and finishing it stalls only while that
// register is still full.
`default_nettype none

module text_console_char_writer_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    tcw_in_if.sink      i_in,
    tcw_out_if.source   o_out,
    tcw_cfg_if.sink     i_cfg
);

    tcw_pkg::t_addr_req                addr_req;
    tcw_pkg::t_mem_req                 mem_req;
    logic [tcw_pkg::ADDR_W-1:0]        addr;
    logic [tcw_pkg::CELL_W-1:0]        rdata;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_out      (o_out),
        .i_cfg      (i_cfg),
        .o_addr_req (addr_req),
        .i_addr     (addr),
        .o_mem_req  (mem_req),
        .i_rdata    (rdata)
    );

    tcw_addr_unit u_addr_unit (
        .i_req  (addr_req),
        .o_addr (addr)
    );

    tcw_cell_store u_cell_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

endmodule

`default_nettype wire

@@ hdl/tcw_addr_unit.sv @@
// Shared address unit: logical row and column to physical cell store address.
`default_nettype none

module tcw_addr_unit (
    input  var tcw_pkg::t_addr_req             i_req,
    output logic [tcw_pkg::ADDR_W-1:0]         o_addr
);

    logic [tcw_pkg::ROW_W:0] sum;
    logic [tcw_pkg::ROW_W:0] prow;

    // Rows are kept in a ring starting at base; wrap once.
    assign sum  = {1'b0, i_req.base} + {1'b0, i_req.row};
    assign prow = (sum >= (tcw_pkg::ROW_W + 1)'(tcw_pkg::STORE_ROWS))
                ? sum - (tcw_pkg::ROW_W + 1)'(tcw_pkg::STORE_ROWS)
                : sum;

    assign o_addr = tcw_pkg::ADDR_W'(prow) * tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS)
                  + tcw_pkg::ADDR_W'(i_req.col);

endmodule

`default_nettype wire

@@ hdl/tcw_cell_store.sv @@
// Character and attribute cell store: one access per cycle, registered read.
`default_nettype none

module tcw_cell_store (
    input  wire                              i_clk,
    input  var tcw_pkg::t_mem_req            i_req,
    output logic [tcw_pkg::CELL_W-1:0]       o_rdata
);

    logic [tcw_pkg::CELL_W-1:0] r_mem [tcw_pkg::STORE_CELLS];
    logic [tcw_pkg::CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hdl/tcw_ctrl.sv @@
// Sequencer: cursor, row ring base, index divide loop, scroll and clear sweeps.
`default_nettype none

module tcw_ctrl (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    tcw_in_if.sink                          i_in,
    tcw_out_if.source                       o_out,
    tcw_cfg_if.sink                         i_cfg,
    output tcw_pkg::t_addr_req              o_addr_req,
    input  wire [tcw_pkg::ADDR_W-1:0]       i_addr,
    output tcw_pkg::t_mem_req               o_mem_req,
    input  wire [tcw_pkg::CELL_W-1:0]       i_rdata
);

    localparam int COL_W  = tcw_pkg::COL_W;
    localparam int ROW_W  = tcw_pkg::ROW_W;
    localparam int ADDR_W = tcw_pkg::ADDR_W;

    tcw_pkg::t_state r_state, n_state;

    logic [tcw_pkg::CHAR_W-1:0]  r_char, n_char;
    logic [tcw_pkg::INDEX_W-1:0] r_rem, n_rem;
    logic [ROW_W-1:0]            r_qrow, n_qrow;
    logic [COL_W-1:0]            r_col, n_col;
    logic [ROW_W-1:0]            r_row, n_row;
    logic [ROW_W-1:0]            r_base, n_base;
    logic [ADDR_W-1:0]           r_cnt, n_cnt;
    logic [tcw_pkg::ATTR_W-1:0]  r_attr, n_attr;
    logic [tcw_pkg::CHAR_W-1:0]  r_res_char, n_res_char;
    logic [tcw_pkg::ATTR_W-1:0]  r_res_attr, n_res_attr;
    logic                        r_out_valid, n_out_valid;
    logic [tcw_pkg::POS_W-1:0]   r_out_pos, n_out_pos;
    logic [tcw_pkg::CHAR_W-1:0]  r_out_char, n_out_char;
    logic [tcw_pkg::ATTR_W-1:0]  r_out_attr, n_out_attr;

    logic [COL_W:0]                 col_nx;
    logic [ROW_W-1:0]               row_nx;
    logic [tcw_pkg::POS_CALC_W-1:0] pos_calc;

    assign i_in.ready  = (r_state == tcw_pkg::ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid           = r_out_valid;
    assign o_out.cursor_position = r_out_pos;
    assign o_out.read_char       = r_out_char;
    assign o_out.read_attribute  = r_out_attr;

    assign pos_calc = tcw_pkg::POS_CALC_W'(r_row)
                    * tcw_pkg::POS_CALC_W'(tcw_pkg::COLUMNS)
                    + tcw_pkg::POS_CALC_W'(r_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::ST_CLEAR;
            r_col       <= '0;
            r_row       <= '0;
            r_base      <= '0;
            r_cnt       <= '0;
            r_attr      <= tcw_pkg::ATTR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_base      <= n_base;
            r_cnt       <= n_cnt;
            r_attr      <= n_attr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char     <= n_char;
        r_rem      <= n_rem;
        r_qrow     <= n_qrow;
        r_res_char <= n_res_char;
        r_res_attr <= n_res_attr;
        r_out_pos  <= n_out_pos;
        r_out_char <= n_out_char;
        r_out_attr <= n_out_attr;
    end

    // Logical row and column of the cell touched this cycle.
    always_comb begin
        o_addr_req.base = r_base;
        o_addr_req.row  = r_row;
        o_addr_req.col  = r_col;
        unique case (r_state)
            tcw_pkg::ST_DIV: begin
                o_addr_req.row = r_qrow;
                o_addr_req.col = r_rem[COL_W-1:0];
            end
            tcw_pkg::ST_PUT: begin
                if (r_char == tcw_pkg::CH_BACKSPACE) begin
                    o_addr_req.col = r_col - COL_W'(1);
                end
            end
            tcw_pkg::ST_SCROLL: begin
                o_addr_req.col = r_cnt[COL_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_char      = r_char;
        n_rem       = r_rem;
        n_qrow      = r_qrow;
        n_col       = r_col;
        n_row       = r_row;
        n_base      = r_base;
        n_cnt       = r_cnt;
        n_attr      = r_attr;
        n_res_char  = r_res_char;
        n_res_attr  = r_res_attr;
        n_out_valid = r_out_valid & ~o_out.ready;
        n_out_pos   = r_out_pos;
        n_out_char  = r_out_char;
        n_out_attr  = r_out_attr;
        col_nx      = {1'b0, r_col};
        row_nx      = r_row;

        o_mem_req.wr_en = 1'b0;
        o_mem_req.rd_en = 1'b0;
        o_mem_req.addr  = i_addr;
        o_mem_req.wdata = '0;

        if (i_cfg.valid) begin
            n_attr = i_cfg.text_attribute;
        end

        unique case (r_state)
            tcw_pkg::ST_CLEAR: begin
                o_mem_req.wr_en = 1'b1;
                o_mem_req.addr  = r_cnt;
                n_cnt           = r_cnt + ADDR_W'(1);
                if (r_cnt == ADDR_W'(tcw_pkg::STORE_CELLS - 1)) begin
                    n_cnt   = '0;
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_char     = i_in.char_code;
                    n_rem      = i_in.cell_index;
                    n_qrow     = '0;
                    n_res_char = '0;
                    n_res_attr = '0;
                    if (i_in.command == tcw_pkg::CMD_PUT) begin
                        n_state = tcw_pkg::ST_PUT;
                    end else if (32'(i_in.cell_index) >= tcw_pkg::CELLS) begin
                        n_state = tcw_pkg::ST_DONE;
                    end else begin
                        n_state = tcw_pkg::ST_DIV;
                    end
                end
            end
            tcw_pkg::ST_DIV: begin
                // Peel one row off the index per cycle.
                if (r_rem >= tcw_pkg::INDEX_W'(tcw_pkg::COLUMNS)) begin
                    n_rem  = r_rem - tcw_pkg::INDEX_W'(tcw_pkg::COLUMNS);
                    n_qrow = r_qrow + ROW_W'(1);
                end else if (r_qrow == ROW_W'(tcw_pkg::ROWS - 1)) begin
                    // Last row is never written: it reads as cleared.
                    n_state = tcw_pkg::ST_DONE;
                end else begin
                    o_mem_req.rd_en = 1'b1;
                    n_state         = tcw_pkg::ST_RD_WAIT;
                end
            end
            tcw_pkg::ST_RD_WAIT: begin
                n_res_char = i_rdata[tcw_pkg::CHAR_W-1:0];
                n_res_attr = i_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
                n_state    = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_PUT: begin
                n_state = tcw_pkg::ST_DONE;
                unique case (r_char)
                    tcw_pkg::CH_BACKSPACE: begin
                        if (r_col != '0) begin
                            o_mem_req.rd_en = 1'b1;
                            n_col           = r_col - COL_W'(1);
                            n_state         = tcw_pkg::ST_BS_WAIT;
                        end
                    end
                    tcw_pkg::CH_TAB: begin
                        col_nx = ({1'b0, r_col} + (COL_W + 1)'(8)) & ~(COL_W + 1)'(7);
                    end
                    tcw_pkg::CH_CR: begin
                        col_nx = '0;
                    end
                    tcw_pkg::CH_LF: begin
                        col_nx = '0;
                        row_nx = r_row + ROW_W'(1);
                    end
                    default: begin
                        o_mem_req.wr_en = 1'b1;
                        o_mem_req.wdata = {r_attr, r_char};
                        col_nx          = {1'b0, r_col} + (COL_W + 1)'(1);
                    end
                endcase
                if (r_char != tcw_pkg::CH_BACKSPACE) begin
                    if (col_nx >= (COL_W + 1)'(tcw_pkg::COLUMNS)) begin
                        col_nx = '0;
                        row_nx = r_row + ROW_W'(1);
                    end
                    n_col = col_nx[COL_W-1:0];
                    if (row_nx == ROW_W'(tcw_pkg::ROWS - 1)) begin
                        // Scroll: advance the ring, then blank the row that wrapped around.
                        n_row   = ROW_W'(tcw_pkg::ROWS - 2);
                        n_base  = (r_base == ROW_W'(tcw_pkg::STORE_ROWS - 1))
                                ? '0 : r_base + ROW_W'(1);
                        n_cnt   = '0;
                        n_state = tcw_pkg::ST_SCROLL;
                    end else begin
                        n_row = row_nx;
                    end
                end
            end
            tcw_pkg::ST_BS_WAIT: begin
                // Keep the attribute, drop the character.
                o_mem_req.wr_en = 1'b1;
                o_mem_req.wdata = {i_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W], tcw_pkg::CH_NUL};
                n_state         = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_SCROLL: begin
                o_mem_req.wr_en = 1'b1;
                o_mem_req.wdata = {r_attr, tcw_pkg::CH_NUL};
                n_cnt           = r_cnt + ADDR_W'(1);
                if (r_cnt == ADDR_W'(tcw_pkg::COLUMNS - 1)) begin
                    n_cnt   = '0;
                    n_state = tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_DONE: begin
                // Hold until the output register is free.
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = tcw_pkg::POS_W'(pos_calc);
                    n_out_char  = r_res_char;
                    n_out_attr  = r_res_attr;
                    n_state     = tcw_pkg::ST_IDLE;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/tcw_checker.sv @@
// Port-level checks for the text console character writer, bound to the top level.
`default_nettype none
`include "text_console_char_writer_core_defines.svh"

module tcw_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             i_in_valid,
    input wire                             i_in_ready,
    input wire                             i_out_valid,
    input wire                             i_out_ready,
    input wire [tcw_pkg::POS_W-1:0]        i_out_pos
);

    // Cursor never rests on the last row; skip the bound when positions alias.
    localparam int POS_LIMIT = (tcw_pkg::STORE_CELLS <= 2048) ? tcw_pkg::STORE_CELLS : 2048;

    `TCW_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_pos), "result beat dropped or changed while stalled")
    `TCW_ASSERT_NXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "input accepted while a command is in flight")
    `TCW_ASSERT_IMP(a_clear_after_reset, i_clk, i_rst_n, !$past(i_rst_n), !i_in_ready, "input ready during clearing sweep")
    `TCW_ASSERT_IMP(a_cursor_bound, i_clk, i_rst_n, i_out_valid, 32'(i_out_pos) < POS_LIMIT, "cursor reported on last row")

endmodule

bind text_console_char_writer_core tcw_checker u_tcw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_pos   (o_out.cursor_position)
);

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for the text console writer: cursor, cell store, scrolling and reads.
`timescale 1ns / 1ps

module tb_top;
    import tcw_pkg::*;

    localparam int LIMIT       = 1_000_000;
    localparam int PHASE_ITEMS = 175;
    localparam int IDLE_PCT    = 12;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] attr;
    } console_reply_t;

    // Screen shadow plus the queue of replies still owed by the block.
    class console_scoreboard;
        logic [CELL_W-1:0] screen [CELLS];
        int unsigned       col;
        int unsigned       row;
        logic [ATTR_W-1:0] attr;
        console_reply_t    replies [$];
        int                errors;

        function new();
            foreach (screen[i]) screen[i] = '0;
            col    = 0;
            row    = 0;
            attr   = ATTR_RESET;
            errors = 0;
        endfunction

        function void set_attribute(logic [ATTR_W-1:0] value);
            attr = value;
        endfunction

        function int unsigned cursor_index();
            return row * COLUMNS + col;
        endfunction

        function void scroll_up();
            for (int i = 0; i + COLUMNS < CELLS; i++) screen[i] = screen[i + COLUMNS];
            for (int i = COLUMNS * (ROWS - 2); i < COLUMNS * (ROWS - 1); i++)
                screen[i] = {attr, CH_NUL};
            if (row >= 1) row = row - 1;
            else col = 0;
        endfunction

        function void put_char(logic [CHAR_W-1:0] c);
            int unsigned pos;
            case (c)
                CH_BACKSPACE: begin
                    if (col > 0) begin
                        col = col - 1;
                        pos = row * COLUMNS + col;
                        // Keep the attribute, drop only the character.
                        if (pos < CELLS) screen[pos][CHAR_W-1:0] = CH_NUL;
                    end
                end
                CH_TAB: col = (col + 8) / 8 * 8;
                CH_CR:  col = 0;
                CH_LF: begin
                    col = 0;
                    row = row + 1;
                end
                default: begin
                    pos = row * COLUMNS + col;
                    if (pos < CELLS) screen[pos] = {attr, c};
                    col = col + 1;
                end
            endcase
            if (col >= COLUMNS) begin
                col = 0;
                row = row + 1;
            end
            if (row >= ROWS - 1) scroll_up();
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] c,
                                   logic [INDEX_W-1:0] idx);
            console_reply_t r;
            r = '0;
            if (cmd == CMD_PUT) begin
                put_char(c);
            end else if (idx < CELLS) begin
                r.ch   = screen[idx][CHAR_W-1:0];
                r.attr = screen[idx][CELL_W-1:CHAR_W];
            end
            r.pos = POS_W'(row * COLUMNS + col);
            replies.push_back(r);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(console_reply_t got);
            console_reply_t want;
            if (replies.size() == 0) begin
                report($sformatf("result pos=%0d char=%02h attr=%02h with none expected",
                                 got.pos, got.ch, got.attr));
                return;
            end
            want = replies.pop_front();
            if (got.pos !== want.pos)
                report($sformatf("cursor_position %0d, expected %0d", got.pos, want.pos));
            if (got.ch !== want.ch)
                report($sformatf("read_char %02h, expected %02h", got.ch, want.ch));
            if (got.attr !== want.attr)
                report($sformatf("read_attribute %02h, expected %02h", got.attr, want.attr));
        endtask

        task check_drained();
            if (replies.size() != 0)
                report($sformatf("%0d expected results never arrived", replies.size()));
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    bit                calm;
    int unsigned       cycles = 0;
    int                items_sent = 0;
    console_scoreboard sb = new();

    tcw_in_if  in_ch ();
    tcw_out_if out_ch ();
    tcw_cfg_if cfg_ch ();

    text_console_char_writer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: check a beat at the falling edge before it is taken, then pick ready.
    initial begin
        console_reply_t got;
        out_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                got = '{out_ch.cursor_position, out_ch.read_char, out_ch.read_attribute};
                sb.check_result(got);
            end
            @(posedge i_clk);
            out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic send_item(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] c,
                             logic [INDEX_W-1:0] idx);
        logic seen;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.command    <= cmd;
        in_ch.char_code  <= c;
        in_ch.cell_index <= idx;
        do begin
            @(negedge i_clk);
            seen = in_ch.ready;
            @(posedge i_clk);
        end while (!seen);
        sb.note_command(cmd, c, idx);
        items_sent++;
    endtask

    task automatic put(logic [CHAR_W-1:0] c);
        send_item(CMD_PUT, c, INDEX_W'($urandom_range(0, 2047)));
    endtask

    task automatic read_cell(int unsigned idx);
        send_item(CMD_READ, CHAR_W'($urandom_range(0, 255)), INDEX_W'(idx));
    endtask

    task automatic random_read();
        int unsigned here;
        here = sb.cursor_index();
        case ($urandom_range(0, 2))
            0: read_cell($urandom_range(0, 2047));
            // Look back over what was just written.
            1: read_cell(here > 100 ? here - $urandom_range(0, 100) : $urandom_range(0, here));
            default: read_cell($urandom_range(COLUMNS * (ROWS - 2), CELLS - 1));
        endcase
    endtask

    task automatic random_line();
        int n;
        int r;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 20);
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 80)      put(CHAR_W'($urandom_range(0, 255)));
            else if (r < 85) put(CH_BACKSPACE);
            else if (r < 89) put(CH_TAB);
            else             random_read();
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            put(CH_LF);
        end else if (r < 70) begin
            put(CH_CR);
            put(CH_LF);
        end else if (r < 80) begin
            put(CH_CR);
        end
    endtask

    task automatic write_attribute(logic [ATTR_W-1:0] value);
        logic seen;
        cfg_ch.valid          <= 1'b1;
        cfg_ch.text_attribute <= value;
        do begin
            @(negedge i_clk);
            seen = cfg_ch.ready;
            @(posedge i_clk);
        end while (!seen);
        cfg_ch.valid <= 1'b0;
        sb.set_attribute(value);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.replies.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [ATTR_W-1:0] attr_list [6];
        int                phase_start;
        i_rst_n               <= 1'b0;
        in_ch.valid           <= 1'b0;
        in_ch.command         <= CMD_PUT;
        in_ch.char_code       <= '0;
        in_ch.cell_index      <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.text_attribute <= '0;
        calm = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: cleared store, read range ends, backspace, tab wrap, CR and LF.
        read_cell(0);
        read_cell(CELLS - 1);
        read_cell(CELLS);
        read_cell(2047);
        put(CH_BACKSPACE);
        put(8'hFF);
        put(8'h00);
        put(CH_BACKSPACE);
        read_cell(1);
        read_cell(0);
        put(CH_TAB);
        put(CH_CR);
        put(CH_LF);
        repeat (10) put(CH_TAB);
        read_cell(COLUMNS);
        drain();

        attr_list[0] = 8'hFF;
        attr_list[1] = 8'h00;
        for (int i = 2; i < 6; i++) attr_list[i] = ATTR_W'($urandom_range(1, 254));

        for (int phase = 0; phase < 6; phase++) begin
            write_attribute(attr_list[phase]);
            calm = (phase == 2);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) random_line();
            drain();
        end

        calm = 1'b0;
        repeat (100) @(posedge i_clk);
        sb.check_drained();
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/tcw_pkg.sv
hdl/tcw_if.sv
hdl/tcw_addr_unit.sv
hdl/tcw_cell_store.sv
hdl/tcw_ctrl.sv
hdl/text_console_char_writer_core.sv
hdl/tcw_checker.sv
bench/tb_top.sv
